/* hw/rtl/qsl_pkg.sv */
`timescale 1ns / 1ps

package qsl_pkg;

    localparam int DEPTH       = 64;
    localparam int KEY_BITS    = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int STACK_SLOTS = DEPTH;

    typedef logic signed [KEY_BITS-1:0] key_t;
    typedef logic [IDX_W-1:0]           idx_t;
    typedef logic [CNT_W-1:0]           cnt_t;

    // One pending range of the sort, low and high index inclusive.
    typedef struct packed {
        idx_t lo;
        idx_t hi;
    } range_t;

    typedef struct packed {
        logic signed [31:0] key_in;
        logic               last_in;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] key_out;
        logic               last_out;
        logic               overflow;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_INIT,
        ST_POP,
        ST_POP_WAIT,
        ST_PIV_WAIT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_FINAL,
        ST_FIN_A,
        ST_FIN_B,
        ST_PUSH_A,
        ST_PUSH_B,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    // Sign-extend or truncate the incoming 32-bit field to the key width.
    function automatic key_t make_key(input logic signed [31:0] raw);
        return key_t'(raw);
    endfunction

endpackage

/* hw/rtl/qsl_ram.sv */
`timescale 1ns / 1ps

module qsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/quicksort_lomuto_sorter.sv */
`timescale 1ns / 1ps

// Sorts a set of up to 64 signed keys in ascending order.
// Input channel (key_valid, key_stall, key_word): one key per word; the word
// with last_in set closes the set. Keys are taken one per cycle while loading;
// a key that arrives with the memory full is dropped and flags overflow.
// After the last word the input stalls while an in-place quicksort runs on the
// key memory, using Lomuto partitioning and a range stack held in a second
// memory. Each element is read and compared with the pivot and, when smaller,
// exchanged with the key at the fill point; each range adds a pop, a pivot
// fetch, a final exchange of the pivot and the pushes of its parts.
// Output channel (sorted_valid, sorted_stall, sorted_word): each sorted key is
// read from memory, then loaded into an output register; last_out marks
// the final key and overflow is set on every word of a set that lost keys.
// A stall on the output simply holds the current word and pauses emission.
// The input opens again as soon as the final word sits in the output register.
// Reset returns the block to loading with an empty set; the memories are not
// cleared, since only written entries are ever read.
module quicksort_lomuto_sorter
    import qsl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      key_valid,
    output logic      key_stall,
    input  in_word_t  key_word,
    output logic      sorted_valid,
    input  logic      sorted_stall,
    output out_word_t sorted_word
);

    state_t    state_reg, state_next;
    cnt_t      count_reg, count_next;
    cnt_t      sp_reg, sp_next;
    cnt_t      k_reg, k_next;
    logic      dropped_reg, dropped_next;
    idx_t      lo_reg, lo_next;
    idx_t      hi_reg, hi_next;
    idx_t      fill_reg, fill_next;
    idx_t      j_reg, j_next;
    key_t      pivot_reg, pivot_next;
    key_t      tmp_reg, tmp_next;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg, out_word_next;

    logic   key_we, key_re;
    idx_t   key_waddr, key_raddr;
    key_t   key_wdata, key_rdata;
    logic   stk_we, stk_re;
    idx_t   stk_waddr, stk_raddr;
    range_t stk_wdata, stk_rdata;

    logic   out_free;
    logic   is_less;
    logic   scan_end;
    cnt_t   p_ext, lo_ext, hi_ext;

    qsl_ram #(
        .WIDTH ($bits(key_t)),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (key_re),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    qsl_ram #(
        .WIDTH ($bits(range_t)),
        .DEPTH (STACK_SLOTS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign key_stall    = (state_reg != ST_LOAD);
    assign sorted_valid = out_valid_reg;
    assign sorted_word  = out_word_reg;

    assign out_free = !out_valid_reg || !sorted_stall;
    assign is_less  = (key_rdata < pivot_reg);
    assign scan_end = (idx_t'(j_reg + idx_t'(1)) == hi_reg);
    assign p_ext    = cnt_t'(fill_reg);
    assign lo_ext   = cnt_t'(lo_reg);
    assign hi_ext   = cnt_t'(hi_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (key_valid && key_word.last_in)
                begin
                    state_next = ST_SORT_INIT;
                end
            end
            ST_SORT_INIT: state_next = ST_POP;
            ST_POP:
            begin
                if (sp_reg == '0)
                begin
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT: state_next = ST_PIV_WAIT;
            ST_PIV_WAIT: state_next = ST_SCAN_RD;
            ST_SCAN_RD:  state_next = ST_SCAN_CMP;
            ST_SCAN_CMP:
            begin
                if (is_less && (fill_reg != j_reg))
                begin
                    state_next = ST_SWAP_A;
                end
                else if (scan_end)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SWAP_A: state_next = ST_SWAP_B;
            ST_SWAP_B:
            begin
                if (scan_end)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_FINAL:
            begin
                if (fill_reg == hi_reg)
                begin
                    state_next = ST_PUSH_A;
                end
                else
                begin
                    state_next = ST_FIN_A;
                end
            end
            ST_FIN_A:  state_next = ST_FIN_B;
            ST_FIN_B:  state_next = ST_PUSH_A;
            ST_PUSH_A: state_next = ST_PUSH_B;
            ST_PUSH_B: state_next = ST_POP;
            ST_EMIT_RD:
            begin
                if (out_free)
                begin
                    state_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD:
            begin
                if (k_reg + cnt_t'(1) == count_reg)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        sp_next        = sp_reg;
        k_next         = k_reg;
        dropped_next   = dropped_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        fill_next      = fill_reg;
        j_next         = j_reg;
        pivot_next     = pivot_reg;
        tmp_next       = tmp_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && sorted_stall;

        key_we    = 1'b0;
        key_waddr = '0;
        key_wdata = '0;
        key_re    = 1'b0;
        key_raddr = '0;
        stk_we    = 1'b0;
        stk_waddr = sp_reg[IDX_W-1:0];
        stk_wdata = '0;
        stk_re    = 1'b0;
        stk_raddr = '0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (key_valid)
                begin
                    if (count_reg < cnt_t'(DEPTH))
                    begin
                        key_we     = 1'b1;
                        key_waddr  = count_reg[IDX_W-1:0];
                        key_wdata  = make_key(key_word.key_in);
                        count_next = count_reg + cnt_t'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
            end
            ST_SORT_INIT:
            begin
                k_next  = '0;
                sp_next = '0;
                if (count_reg >= cnt_t'(2))
                begin
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = '{lo: '0, hi: idx_t'(count_reg - cnt_t'(1))};
                    sp_next   = cnt_t'(1);
                end
            end
            ST_POP:
            begin
                if (sp_reg != '0)
                begin
                    stk_re    = 1'b1;
                    stk_raddr = idx_t'(sp_reg - cnt_t'(1));
                    sp_next   = sp_reg - cnt_t'(1);
                end
            end
            ST_POP_WAIT:
            begin
                lo_next   = stk_rdata.lo;
                hi_next   = stk_rdata.hi;
                key_re    = 1'b1;
                key_raddr = stk_rdata.hi;
            end
            ST_PIV_WAIT:
            begin
                pivot_next = key_rdata;
                fill_next  = lo_reg;
                j_next     = lo_reg;
            end
            ST_SCAN_RD:
            begin
                key_re    = 1'b1;
                key_raddr = j_reg;
            end
            ST_SCAN_CMP:
            begin
                tmp_next = key_rdata;
                if (is_less && (fill_reg != j_reg))
                begin
                    // Fetch the key at the fill point to exchange it.
                    key_re    = 1'b1;
                    key_raddr = fill_reg;
                end
                else if (is_less)
                begin
                    fill_next = fill_reg + idx_t'(1);
                    j_next    = j_reg + idx_t'(1);
                end
                else
                begin
                    j_next = j_reg + idx_t'(1);
                end
            end
            ST_SWAP_A:
            begin
                key_we    = 1'b1;
                key_waddr = fill_reg;
                key_wdata = tmp_reg;
                tmp_next  = key_rdata;
            end
            ST_SWAP_B:
            begin
                key_we    = 1'b1;
                key_waddr = j_reg;
                key_wdata = tmp_reg;
                fill_next = fill_reg + idx_t'(1);
                j_next    = j_reg + idx_t'(1);
            end
            ST_FINAL:
            begin
                if (fill_reg != hi_reg)
                begin
                    key_re    = 1'b1;
                    key_raddr = fill_reg;
                end
            end
            ST_FIN_A:
            begin
                key_we    = 1'b1;
                key_waddr = fill_reg;
                key_wdata = pivot_reg;
                tmp_next  = key_rdata;
            end
            ST_FIN_B:
            begin
                key_we    = 1'b1;
                key_waddr = hi_reg;
                key_wdata = tmp_reg;
            end
            ST_PUSH_A:
            begin
                // The right part goes first only when a left part exists.
                if ((fill_reg > lo_reg) && (hi_ext > p_ext + cnt_t'(1))
                    && (sp_reg < cnt_t'(STACK_SLOTS)))
                begin
                    stk_we    = 1'b1;
                    stk_wdata = '{lo: idx_t'(p_ext + cnt_t'(1)), hi: hi_reg};
                    sp_next   = sp_reg + cnt_t'(1);
                end
            end
            ST_PUSH_B:
            begin
                if (sp_reg < cnt_t'(STACK_SLOTS))
                begin
                    if (fill_reg > lo_reg)
                    begin
                        if (p_ext > lo_ext + cnt_t'(1))
                        begin
                            stk_we    = 1'b1;
                            stk_wdata = '{lo: lo_reg, hi: idx_t'(p_ext - cnt_t'(1))};
                            sp_next   = sp_reg + cnt_t'(1);
                        end
                    end
                    else if (hi_ext > p_ext + cnt_t'(1))
                    begin
                        stk_we    = 1'b1;
                        stk_wdata = '{lo: idx_t'(p_ext + cnt_t'(1)), hi: hi_reg};
                        sp_next   = sp_reg + cnt_t'(1);
                    end
                end
            end
            ST_EMIT_RD:
            begin
                if (out_free)
                begin
                    key_re    = 1'b1;
                    key_raddr = k_reg[IDX_W-1:0];
                end
            end
            ST_EMIT_LD:
            begin
                out_valid_next         = 1'b1;
                out_word_next.key_out  = 32'(key_rdata);
                out_word_next.last_out = (k_reg + cnt_t'(1) == count_reg);
                out_word_next.overflow = dropped_reg;
                k_next                 = k_reg + cnt_t'(1);
                if (k_reg + cnt_t'(1) == count_reg)
                begin
                    count_next   = '0;
                    dropped_next = 1'b0;
                    sp_next      = '0;
                    k_next       = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            sp_reg        <= '0;
            k_reg         <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sp_reg        <= sp_next;
            k_reg         <= k_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        fill_reg     <= fill_next;
        j_reg        <= j_next;
        pivot_reg    <= pivot_next;
        tmp_reg      <= tmp_next;
        out_word_reg <= out_word_next;
    end

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(DEPTH))
        else $error("key count exceeds memory depth");

    a_stack_bound : assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= cnt_t'(STACK_SLOTS))
        else $error("range stack pointer out of range");

    a_scan_order : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_RD) |-> ((fill_reg <= j_reg) && (j_reg < hi_reg)))
        else $error("partition indices out of order");

    a_emit_free : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_LD) |-> !out_valid_reg)
        else $error("output word overwritten before it was taken");
`endif

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import qsl_pkg::*;

    // Holds the keys of the set now loading, sorts them the way the block does
    // and keeps the sorted words that the output has yet to deliver.
    class sorted_order_tracker;
        key_t      keys[DEPTH];
        int        held;
        bit        dropped;
        out_word_t awaited[$];
        int        mismatches;
        int        keys_emitted;

        function void exchange(int a, int b);
            key_t t;
            t = keys[a];
            keys[a] = keys[b];
            keys[b] = t;
        endfunction

        // In-place Lomuto quicksort over the held keys with an explicit range stack.
        function void quicksort_set();
            range_t ranges[$];
            range_t r;
            int     lo;
            int     hi;
            int     fill;
            key_t   pivot;
            if (held >= 2)
                ranges.push_back('{lo: idx_t'(0), hi: idx_t'(held - 1)});
            while (ranges.size() > 0)
            begin
                r = ranges.pop_back();
                lo = r.lo;
                hi = r.hi;
                pivot = keys[hi];
                fill = lo;
                for (int j = lo; j < hi; j++)
                begin
                    if (keys[j] < pivot)
                    begin
                        exchange(fill, j);
                        fill++;
                    end
                end
                exchange(fill, hi);
                // Ranges shorter than two keys are never pushed.
                if (hi > fill + 1)
                    ranges.push_back('{lo: idx_t'(fill + 1), hi: idx_t'(hi)});
                if (fill > lo + 1)
                    ranges.push_back('{lo: idx_t'(lo), hi: idx_t'(fill - 1)});
            end
        endfunction

        function void absorb_key(in_word_t w);
            out_word_t want;
            // A key arriving with the memory full is lost, even the closing one.
            if (held < DEPTH)
            begin
                keys[held] = key_t'(w.key_in);
                held++;
            end
            else
                dropped = 1'b1;
            if (w.last_in)
            begin
                quicksort_set();
                for (int k = 0; k < held; k++)
                begin
                    want.key_out  = keys[k];
                    want.last_out = (k == held - 1);
                    want.overflow = dropped;
                    awaited.push_back(want);
                end
                held = 0;
                dropped = 1'b0;
            end
        endfunction

        function void check_emitted(out_word_t got);
            out_word_t want;
            keys_emitted++;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sorted word: key=%0d last=%b overflow=%b",
                             got.key_out, got.last_out, got.overflow);
                return;
            end
            want = awaited.pop_front();
            if (got.key_out !== want.key_out || got.last_out !== want.last_out ||
                got.overflow !== want.overflow)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("sorted word %0d: got key=%0d last=%b overflow=%b, %s%0d last=%b overflow=%b",
                             keys_emitted, got.key_out, got.last_out, got.overflow,
                             "expected key=", want.key_out, want.last_out, want.overflow);
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      key_valid = 1'b0;
    logic      key_stall;
    in_word_t  key_word = '0;
    logic      sorted_valid;
    logic      sorted_stall = 1'b0;
    out_word_t sorted_word;

    sorted_order_tracker tracker = new();
    int                  quiet_words = 0;

    quicksort_lomuto_sorter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_stall    (key_stall),
        .key_word     (key_word),
        .sorted_valid (sorted_valid),
        .sorted_stall (sorted_stall),
        .sorted_word  (sorted_word)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && key_valid && !key_stall)
            tracker.absorb_key(key_word);
        if (rst_n && sorted_valid && !sorted_stall)
            tracker.check_emitted(sorted_word);
    end

    function automatic int sender_gap();
        int unsigned r;
        if (quiet_words > 0)
        begin
            quiet_words--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet_words = 30;
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Mostly full-range keys, with a share of small values so that sets hold duplicates.
    function automatic logic signed [31:0] pick_key();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return $urandom;
        if (sel < 9)
            return $signed($urandom_range(0, 15)) - 8;
        return ($urandom_range(0, 1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endfunction

    task automatic send_key(input logic signed [31:0] k, input logic closes);
        int gap;
        key_valid <= 1'b1;
        key_word  <= '{key_in: k, last_in: closes};
        @(posedge clk);
        while (key_stall)
            @(posedge clk);
        gap = sender_gap();
        if (gap > 0)
        begin
            key_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_batch(input logic signed [31:0] batch[$]);
        foreach (batch[i])
            send_key(batch[i], i == batch.size() - 1);
    endtask

    initial
    begin : receiver
        int unsigned span;
        bit          hold_done;
        hold_done = 1'b0;
        @(posedge clk);
        forever
        begin
            // One long hold-off so that the sorter fills up and stalls its input.
            if (!hold_done && tracker.keys_emitted >= 40)
            begin
                hold_done = 1'b1;
                sorted_stall <= 1'b1;
                repeat (600) @(posedge clk);
            end
            span = $urandom_range(0, 99);
            if (span < 55)
            begin
                sorted_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else if (span < 90)
            begin
                sorted_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else if (span < 95)
            begin
                sorted_stall <= 1'b1;
                repeat ($urandom_range(15, 60)) @(posedge clk);
            end
            else
            begin
                sorted_stall <= 1'b0;
                repeat ($urandom_range(40, 120)) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        logic signed [31:0] batch[$];
        int                 sent;
        int                 size;
        int                 set_no;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sets of a single key: the two extremes, zero and minus one.
        send_key(32'sh8000_0000, 1'b1);
        send_key(32'sh7fff_ffff, 1'b1);
        send_key(32'sh0000_0000, 1'b1);
        send_key(32'shffff_ffff, 1'b1);
        batch = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0000, 32'shffff_ffff,
                  32'sh0000_0001};
        send_batch(batch);
        batch = '{32'sh0000_0003, 32'sh0000_0003, 32'sh0000_0003, 32'sh0000_0003};
        send_batch(batch);
        // Sorted input puts the largest key in pivot position every time.
        batch = '{32'shffff_fffe, 32'shffff_ffff, 32'sh0000_0000, 32'sh0000_0001,
                  32'sh0000_0002};
        send_batch(batch);
        batch = '{32'sh0000_0005, 32'sh0000_0004, 32'sh0000_0003, 32'sh0000_0002,
                  32'sh0000_0001};
        send_batch(batch);

        sent = 0;
        set_no = 0;
        while (sent < 207)
        begin
            // The first random set overruns the memory by one, so its closing key is lost.
            if (set_no == 0)
                size = DEPTH + 1;
            else if ($urandom_range(0, 11) == 0)
                size = $urandom_range(DEPTH - 1, DEPTH + 2);
            else
                size = $urandom_range(1, 12);
            for (int i = 0; i < size; i++)
                send_key(pick_key(), i == size - 1);
            sent += size;
            set_no++;
        end

        key_valid <= 1'b0;
        @(posedge clk);
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("quicksort_lomuto_sorter verification clean");
        else
            $display("quicksort_lomuto_sorter verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("quicksort_lomuto_sorter verification failed");
        $finish;
    end

endmodule
